// File: sv/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the string intern table: operation codes,
// character width and the key buffer control group.
// ----------------------------------------------------------------------------
package sit_pkg;

  // width of one stored character
  localparam int CHAR_BITS = 8;

  // operation codes carried in tuser of the input channel
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // key buffer control from the sequencer
  typedef struct packed {
    logic append;
    logic clear;
  } key_ctl_t;

endpackage

// File: sv/string_intern_table.sv
// ----------------------------------------------------------------------------
// string_intern_table
// Interns zero-terminated keys into a table of fixed-length entries and
// reads back single stored characters.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one transaction per character push or character read; in_tuser
//           selects the operation. A push of a nonzero character gives no
//           result; a push of zero ends the key.
//   out_* : one result transaction per key end and per read.
//   A key end compares the stored entries against the key, one whole entry
//   per cycle through the row comparator, at most ENTRIES of them; a read
//   goes through one registered entry memory read. An empty key and a read
//   out of range go to the result without a memory access.
//   in_tready is high only while the sequencer is idle, so one item is at
//   work at a time; the result register lets the next item be taken while
//   a result waits. A stalled receiver holds out_tdata; a following result
//   waits in the sequencer until the result register is free.
//   Reset clears the key buffer, the entry count and all control state.
//   The entry memory is not cleared: only entries below the entry count are
//   ever compared or read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module string_intern_table
  import sit_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int ENTRY_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], entry_index[13:8], char_position[18:14], zero[23:19]
  input  logic [23:0] in_tdata,
  // opcode[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot_index[5:0], was_present[6], table_full[7], read_char[15:8],
  // entry_count[22:16], zero[23]
  output logic [23:0] out_tdata
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CHAR_W  = $clog2(ENTRY_CHARS);
  localparam int CMP_W   = (CNT_W > 6) ? CNT_W : 6;
  localparam int PLIM_W  = $clog2(ENTRY_CHARS + 1);
  localparam int PCMP_W  = (PLIM_W > 5) ? PLIM_W : 5;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_STORE  = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // input fields
  logic [7:0] in_char;
  logic [5:0] in_idx;
  logic [4:0] in_pos;
  assign in_char = in_tdata[7:0];
  assign in_idx  = in_tdata[13:8];
  assign in_pos  = in_tdata[18:14];

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CHAR_W-1:0]   pos_r, pos_nxt;
  logic [IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic                res_present_r, res_present_nxt;
  logic                res_full_r, res_full_nxt;
  logic [7:0]          res_char_r, res_char_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;

  key_ctl_t                              key_ctl;
  logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] key;
  logic                                  key_empty;
  logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] rd_data;
  logic                                  wr_en, rd_en;
  logic [IDX_W-1:0]                      wr_addr, rd_addr;

  logic                accept;
  logic                has_room;
  logic                row_match;
  logic [CNT_W-1:0]    scan_next_cnt;
  logic                read_ok;

  assign accept        = in_tvalid && in_tready;
  assign in_tready     = (state_r == S_IDLE);
  assign has_room      = (count_r < CNT_W'(ENTRIES));
  assign row_match     = (rd_data == key);
  assign scan_next_cnt = CNT_W'(scan_r) + CNT_W'(1);
  assign read_ok       = (CMP_W'(in_idx) < CMP_W'(count_r)) &&
                         (PCMP_W'(in_pos) < PCMP_W'(ENTRY_CHARS));

  sit_key_buf #(
    .ENTRY_CHARS (ENTRY_CHARS),
    .CHAR_W      (CHAR_W)
  ) u_key_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (key_ctl),
    .char_in   (in_char),
    .key       (key),
    .key_empty (key_empty)
  );

  sit_entry_mem #(
    .ENTRIES     (ENTRIES),
    .ENTRY_CHARS (ENTRY_CHARS),
    .IDX_W       (IDX_W)
  ) u_entry_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    scan_nxt        = scan_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    res_slot_nxt    = res_slot_r;
    res_present_nxt = res_present_r;
    res_full_nxt    = res_full_r;
    res_char_nxt    = res_char_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    key_ctl         = '0;
    wr_en           = 1'b0;
    wr_addr         = IDX_W'(count_r);
    rd_en           = 1'b0;
    rd_addr         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_slot_nxt    = '0;
          res_present_nxt = 1'b0;
          res_full_nxt    = 1'b0;
          res_char_nxt    = '0;
          if (in_tuser == OP_PUSH) begin
            if (in_char != '0) begin
              key_ctl.append = 1'b1;
            end else if (key_empty) begin
              // empty key: report the first free slot, store nothing
              key_ctl.clear = 1'b1;
              if (has_room) begin
                res_slot_nxt = IDX_W'(count_r);
              end else begin
                res_full_nxt = 1'b1;
              end
              state_nxt = S_EMIT;
            end else if (count_r == '0) begin
              state_nxt = S_STORE;
            end else begin
              // start scan at entry zero
              rd_en     = 1'b1;
              rd_addr   = '0;
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            pos_nxt = CHAR_W'(in_pos);
            if (read_ok) begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(in_idx);
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end

      // compare one stored entry per cycle
      S_SCAN: begin
        if (row_match) begin
          res_slot_nxt    = scan_r;
          res_present_nxt = 1'b1;
          key_ctl.clear   = 1'b1;
          state_nxt       = S_EMIT;
        end else if (scan_next_cnt < count_r) begin
          rd_en    = 1'b1;
          rd_addr  = IDX_W'(scan_next_cnt);
          scan_nxt = IDX_W'(scan_next_cnt);
        end else begin
          state_nxt = S_STORE;
        end
      end

      // no match: store in the first free entry, or flag a full table
      S_STORE: begin
        if (has_room) begin
          wr_en        = 1'b1;
          res_slot_nxt = IDX_W'(count_r);
          count_nxt    = count_r + CNT_W'(1);
        end else begin
          res_full_nxt = 1'b1;
        end
        key_ctl.clear = 1'b1;
        state_nxt     = S_EMIT;
      end

      // pick the character from the read row
      S_RDWAIT: begin
        res_char_nxt = rd_data[pos_r];
        state_nxt    = S_EMIT;
      end

      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, 7'(count_r), res_char_r, res_full_r,
                           res_present_r, 6'(res_slot_r)};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    pos_r         <= pos_nxt;
    res_slot_r    <= res_slot_nxt;
    res_present_r <= res_present_nxt;
    res_full_r    <= res_full_nxt;
    res_char_r    <= res_char_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/sit_entry_mem.sv
// ----------------------------------------------------------------------------
// sit_entry_mem
// Entry store: one row per table entry, one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module sit_entry_mem
  import sit_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int ENTRY_CHARS = 32,
  parameter int IDX_W       = $clog2(ENTRIES)
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [IDX_W-1:0]                      wr_addr,
  input  logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] wr_data,
  input  logic                                  rd_en,
  input  logic [IDX_W-1:0]                      rd_addr,
  output logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] rd_data
);

  logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] mem [ENTRIES];

  // row write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered row read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/sit_key_buf.sv
// ----------------------------------------------------------------------------
// sit_key_buf
// Key collector: appends pushed characters up to one less than the entry
// length and presents the whole key as one row.
// ----------------------------------------------------------------------------
module sit_key_buf
  import sit_pkg::*;
#(
  parameter int ENTRY_CHARS = 32,
  parameter int CHAR_W      = $clog2(ENTRY_CHARS)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  key_ctl_t                              ctl,
  input  logic [CHAR_BITS-1:0]                  char_in,
  output logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] key,
  output logic                                  key_empty
);

  logic [ENTRY_CHARS-1:0][CHAR_BITS-1:0] key_r, key_nxt;
  logic [CHAR_W-1:0]                     len_r, len_nxt;

  // append or clear
  always_comb begin
    key_nxt = key_r;
    len_nxt = len_r;
    if (ctl.clear) begin
      key_nxt = '0;
      len_nxt = '0;
    end else if (ctl.append && (len_r < CHAR_W'(ENTRY_CHARS - 1))) begin
      key_nxt[len_r] = char_in;
      len_nxt        = len_r + CHAR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      len_r <= '0;
    end else begin
      key_r <= key_nxt;
      len_r <= len_nxt;
    end
  end

  assign key       = key_r;
  assign key_empty = (len_r == '0);

endmodule

// File: verif/string_intern_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_table_tb
// Self-checking bench for the string intern table. Key characters and
// character reads go in through the input stream. A scoreboard keeps its own
// copy of the entry rows and the key being built, works out every result and
// compares it field by field with the output stream. Both sides idle at
// random, and the receiver holds off once for a long time so that the block
// fills up.
// ----------------------------------------------------------------------------

localparam int TB_ENTRIES  = 64;
localparam int TB_CHARS    = 32;
localparam int ROW_BITS    = TB_CHARS * 8;

class intern_scoreboard;

  typedef struct packed {
    logic [5:0] slot;
    logic       present;
    logic       full;
    logic [7:0] rchar;
    logic [6:0] count;
  } intern_result_t;

  logic [ROW_BITS-1:0] rows [TB_ENTRIES];
  logic [ROW_BITS-1:0] key_row;
  int                  key_len;
  int                  n_rows;
  intern_result_t      pending [$];
  int                  errors;

  function new();
    foreach (rows[i]) rows[i] = '0;
    key_row = '0;
    key_len = 0;
    n_rows  = 0;
    errors  = 0;
  endfunction

  // one line per mismatch, printing capped
  task report(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  task compare_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d, wanted %0d", name, got, want));
  endtask

  // accepted input transaction: update the table and queue any result
  function void note_input(logic op, logic [7:0] ch, logic [5:0] idx, logic [4:0] pos);
    intern_result_t res;
    int             hit;
    int             e;
    res = '0;
    if (op == sit_pkg::OP_PUSH) begin
      if (ch != 8'd0) begin
        // characters past the last usable position are dropped
        if (key_len < TB_CHARS - 1) begin
          key_row[key_len*8 +: 8] = ch;
          key_len++;
        end
        return;
      end
      // key end: first matching row, else first free row, else table full
      hit = -1;
      if (key_len != 0) begin
        for (e = 0; e < n_rows; e++) begin
          if (hit < 0 && rows[e] == key_row) hit = e;
        end
      end
      if (hit >= 0) begin
        res.slot    = 6'(hit);
        res.present = 1'b1;
      end else if (n_rows < TB_ENTRIES) begin
        res.slot = 6'(n_rows);
        if (key_len != 0) begin
          rows[n_rows] = key_row;
          n_rows++;
        end
      end else begin
        res.full = 1'b1;
      end
      key_row = '0;
      key_len = 0;
    end else if (int'(idx) < n_rows && int'(pos) < TB_CHARS) begin
      res.rchar = rows[idx][int'(pos)*8 +: 8];
    end
    res.count = 7'(n_rows);
    pending.push_back(res);
  endfunction

  // accepted result transaction against the oldest outstanding one
  task check_result(input logic [23:0] data);
    intern_result_t want;
    if (pending.size() == 0) begin
      report($sformatf("result %h with nothing outstanding", data));
      return;
    end
    want = pending.pop_front();
    compare_field("slot_index", data[5:0], want.slot);
    compare_field("was_present", data[6], want.present);
    compare_field("table_full", data[7], want.full);
    compare_field("read_char", data[15:8], want.rchar);
    compare_field("entry_count", data[22:16], want.count);
  endtask

endclass

module string_intern_table_tb;
  import sit_pkg::*;

  localparam int HOLD_START  = 2000;
  localparam int HOLD_LEN    = 500;
  localparam int QUIET_START = 10000;
  localparam int QUIET_END   = 16000;
  localparam int N_ITEMS     = 1950;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = OP_PUSH;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int items_sent = 0;
  int run_cycles = 0;

  intern_scoreboard sb = new();

  always #10 clk = ~clk;

  string_intern_table #(
    .ENTRIES    (TB_ENTRIES),
    .ENTRY_CHARS(TB_CHARS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // input transaction tap
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tuser, in_tdata[7:0], in_tdata[13:8], in_tdata[18:14]);
  end

  // result transaction tap
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stalls, one long hold-off, one stretch always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= HOLD_START && run_cycles < HOLD_START + HOLD_LEN)
        out_tready <= 1'b0;
      else if (run_cycles >= QUIET_START && run_cycles < QUIET_END)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(0, 99) >= 16);
    end
  end

  // offer one transaction, with an occasional gap, and wait for acceptance
  task automatic send_item(input logic op, input logic [7:0] ch,
                           input logic [5:0] idx, input logic [4:0] pos);
    if (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, pos, idx, ch};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  initial begin
    int         pick;
    int         key_len;
    logic [7:0] ch;
    logic [5:0] idx;
    logic [4:0] pos;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, empty key, extreme characters, repeats, prefixes
    send_item(OP_READ, 8'h00, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h00, 6'd63, 5'd31);
    send_item(OP_PUSH, 8'hFF, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h01, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h00, 6'd0, 5'd0);
    send_item(OP_READ, 8'hFF, 6'd0, 5'd0);
    send_item(OP_READ, 8'h00, 6'd0, 5'd1);
    send_item(OP_READ, 8'h00, 6'd0, 5'd31);
    send_item(OP_READ, 8'h00, 6'd63, 5'd31);
    send_item(OP_READ, 8'h00, 6'd1, 5'd0);
    send_item(OP_PUSH, 8'hFF, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h01, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h00, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h01, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h00, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'hFF, 6'd0, 5'd0);
    send_item(OP_PUSH, 8'h00, 6'd0, 5'd0);
    send_item(OP_READ, 8'h00, 6'd1, 5'd0);
    send_item(OP_PUSH, 8'h00, 6'd0, 5'd0);

    // random: mostly short keys over a small alphabet so that repeats hit,
    // some overlong keys, reads and stray terminators
    while (items_sent < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if (sb.n_rows > 0 && $urandom_range(0, 3) != 0)
          idx = 6'($urandom_range(0, sb.n_rows - 1));
        else
          idx = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 3) != 0)
          pos = 5'($urandom_range(0, 4));
        else
          pos = 5'($urandom_range(0, 31));
        send_item(OP_READ, 8'($urandom), idx, pos);
      end else if (pick < 30) begin
        send_item(OP_PUSH, 8'h00, 6'($urandom), 5'($urandom));
      end else begin
        if ($urandom_range(0, 99) < 4)
          key_len = $urandom_range(29, 40);
        else
          key_len = $urandom_range(1, 3);
        repeat (key_len) begin
          if ($urandom_range(0, 19) == 0)
            ch = 8'($urandom_range(1, 255));
          else
            ch = 8'($urandom_range(8'h61, 8'h64));
          send_item(OP_PUSH, ch, 6'($urandom), 5'($urandom));
        end
        send_item(OP_PUSH, 8'h00, 6'($urandom), 5'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow for a full scan before the verdict
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
